/* rtl/sdio_pkg.sv */
// ----------------------------------------------------------------------------
// sdio_pkg
// Shared constants and types for the two-wire serial register master.
// ----------------------------------------------------------------------------
`default_nettype none

package sdio_pkg;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_RELEASE_DELAY = 1'b0,
    CFG_SAMPLE_DELAY  = 1'b1
  } cfg_index_t;

  // Reset values of the delay registers
  localparam logic [7:0] RELEASE_DELAY_RESET = 8'd20;
  localparam logic [7:0] SAMPLE_DELAY_RESET  = 8'd80;

  // Bit counts, loaded as count minus one
  localparam logic [3:0] WRITE_LAST_BIT   = 4'd15;
  localparam logic [3:0] BYTE_LAST_BIT    = 4'd7;

endpackage

`default_nettype wire

/* rtl/sdio_serial_register_master.sv */
// ----------------------------------------------------------------------------
// sdio_serial_register_master
// Master for a two-wire half-duplex serial port: each input word is one tick
// of the bit-level waveform, each result word gives the pin levels of it.
// ----------------------------------------------------------------------------
// The result word is registered: it appears in the cycle after its input word is accepted.
// Throughput: one word per cycle; the output register is reloaded in the
// same cycle it is taken, so the input side only stalls while a result waits.
// Reset: waveform state goes idle (clock high, data line released), delay
// registers return to 20 and 80 ticks, the output register is emptied.
`default_nettype none

module sdio_serial_register_master
  import sdio_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration write port
  input  wire logic       cfg_write,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  // input channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       start_req,
  input  wire logic       is_write,
  input  wire logic [6:0] reg_address,
  input  wire logic [7:0] write_data,
  input  wire logic       sdio_in,
  // output channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            sck_level,
  output logic            sdio_out,
  output logic            sdio_drive,
  output logic            busy_res,
  output logic            read_valid,
  output logic [7:0]      read_data
);

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_SEND_WRITE = 3'd1,
    PH_SEND_READ  = 3'd2,
    PH_RELEASE    = 3'd3,
    PH_SAMPLE     = 3'd4,
    PH_RECEIVE    = 3'd5
  } phase_t;

  logic [7:0]  release_delay;
  logic [7:0]  sample_delay;

  phase_t      phase,         phase_next;
  logic [3:0]  bit_counter,   bit_counter_next;
  logic        clock_half,    clock_half_next;
  logic [7:0]  delay_counter, delay_counter_next;
  logic [15:0] send_shift,    send_shift_next;
  logic [7:0]  receive_shift, receive_shift_next;
  logic        drive_enable,  drive_enable_next;
  logic        done_next;
  logic        accept;

  // Take a new word when the result register is empty or being emptied
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Next waveform state for one tick
  always_comb begin
    phase_next         = phase;
    bit_counter_next   = bit_counter;
    clock_half_next    = clock_half;
    delay_counter_next = delay_counter;
    send_shift_next    = send_shift;
    receive_shift_next = receive_shift;
    drive_enable_next  = drive_enable;
    done_next          = 1'b0;

    case (phase)
      PH_IDLE: begin
        if (start_req) begin
          drive_enable_next = 1'b1;
          clock_half_next   = 1'b0;
          if (is_write) begin
            send_shift_next  = {1'b1, reg_address, write_data};
            bit_counter_next = WRITE_LAST_BIT;
            phase_next       = PH_SEND_WRITE;
          end else begin
            send_shift_next  = {1'b0, reg_address, 8'h00};
            bit_counter_next = BYTE_LAST_BIT;
            phase_next       = PH_SEND_READ;
          end
        end
      end
      PH_SEND_WRITE, PH_SEND_READ: begin
        if (!clock_half) begin
          clock_half_next = 1'b1;
        end else if (bit_counter == 4'd0) begin
          if (phase == PH_SEND_WRITE) begin
            phase_next = PH_IDLE;
          end else if (release_delay != 8'd0) begin
            phase_next         = PH_RELEASE;
            delay_counter_next = release_delay - 8'd1;
          end else begin
            // no release wait: drop the line right away
            drive_enable_next = 1'b0;
            if (sample_delay != 8'd0) begin
              phase_next         = PH_SAMPLE;
              delay_counter_next = sample_delay - 8'd1;
            end else begin
              phase_next       = PH_RECEIVE;
              bit_counter_next = BYTE_LAST_BIT;
              clock_half_next  = 1'b0;
            end
          end
        end else begin
          bit_counter_next = bit_counter - 4'd1;
          send_shift_next  = {send_shift[14:0], 1'b0};
          clock_half_next  = 1'b0;
        end
      end
      PH_RELEASE: begin
        if (delay_counter == 8'd0) begin
          drive_enable_next = 1'b0;
          if (sample_delay != 8'd0) begin
            phase_next         = PH_SAMPLE;
            delay_counter_next = sample_delay - 8'd1;
          end else begin
            phase_next       = PH_RECEIVE;
            bit_counter_next = BYTE_LAST_BIT;
            clock_half_next  = 1'b0;
          end
        end else begin
          delay_counter_next = delay_counter - 8'd1;
        end
      end
      PH_SAMPLE: begin
        if (delay_counter == 8'd0) begin
          phase_next       = PH_RECEIVE;
          bit_counter_next = BYTE_LAST_BIT;
          clock_half_next  = 1'b0;
        end else begin
          delay_counter_next = delay_counter - 8'd1;
        end
      end
      PH_RECEIVE: begin
        if (!clock_half) begin
          clock_half_next    = 1'b1;
          receive_shift_next = {receive_shift[6:0], sdio_in};
        end else if (bit_counter == 4'd0) begin
          // byte complete: take the line back and report it
          phase_next        = PH_IDLE;
          drive_enable_next = 1'b1;
          done_next         = 1'b1;
        end else begin
          bit_counter_next = bit_counter - 4'd1;
          clock_half_next  = 1'b0;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        clock_half_next = 1'b1;
      end
    endcase
  end

  // Delay registers
  always_ff @(posedge clk) begin
    if (rst) begin
      release_delay <= RELEASE_DELAY_RESET;
      sample_delay  <= SAMPLE_DELAY_RESET;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_RELEASE_DELAY: release_delay <= cfg_data;
        CFG_SAMPLE_DELAY:  sample_delay  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the waveform state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_counter   <= 4'd0;
      clock_half    <= 1'b1;
      delay_counter <= 8'd0;
      send_shift    <= 16'h0000;
      receive_shift <= 8'h00;
      drive_enable  <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      bit_counter   <= bit_counter_next;
      clock_half    <= clock_half_next;
      delay_counter <= delay_counter_next;
      send_shift    <= send_shift_next;
      receive_shift <= receive_shift_next;
      drive_enable  <= drive_enable_next;
    end
  end

  // Result register: hold until taken, reload on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sck_level  <= clock_half_next;
      sdio_out   <= drive_enable_next & send_shift_next[15];
      sdio_drive <= drive_enable_next;
      busy_res   <= (phase_next != PH_IDLE);
      read_valid <= done_next;
      read_data  <= done_next ? receive_shift : 8'h00;
    end
  end

  // Checks
  a_idle_clock_high: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> clock_half)
    else $error("clock not high while idle");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_valid) |-> (!busy_res && sdio_drive))
    else $error("read completion while busy or line released");

  a_data_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !read_valid) |-> (read_data == 8'h00))
    else $error("read data without completion");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result waits");

  a_released_phases: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SAMPLE || phase == PH_RECEIVE) |-> !drive_enable)
    else $error("line driven while receiving");

endmodule

`default_nettype wire

/* tb/sdio_pin_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdio_pin_checker
// Watches the tick and pin-level channels of the serial register master,
// predicts the pin levels of every accepted tick word and compares them
// against the result words in order.
// ----------------------------------------------------------------------------

module sdio_pin_checker
  import sdio_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic       start_req,
  input  wire logic       is_write,
  input  wire logic [6:0] reg_address,
  input  wire logic [7:0] write_data,
  input  wire logic       sdio_in,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic       sck_level,
  input  wire logic       sdio_out,
  input  wire logic       sdio_drive,
  input  wire logic       busy_res,
  input  wire logic       read_valid,
  input  wire logic [7:0] read_data,
  output int              mismatches,
  output int              pending,
  output int              bytes_read
);

  typedef enum logic [2:0] {
    WAVE_IDLE       = 3'd0,
    WAVE_SEND_WRITE = 3'd1,
    WAVE_SEND_READ  = 3'd2,
    WAVE_RELEASE    = 3'd3,
    WAVE_SAMPLE     = 3'd4,
    WAVE_RECEIVE    = 3'd5
  } wave_phase_t;

  typedef struct packed {
    logic       sck;
    logic       sdo;
    logic       drive;
    logic       busy;
    logic       rvalid;
    logic [7:0] rdata;
  } pin_levels_t;

  // Shadow copy of the waveform state and the delay registers
  wave_phase_t wave_phase;
  logic [4:0]  bits_left;
  logic        sck_high;
  logic [7:0]  wait_left;
  logic [15:0] tx_shift;
  logic [7:0]  rx_shift;
  logic        line_driven;
  logic [7:0]  release_ticks;
  logic [7:0]  sample_ticks;

  pin_levels_t expected_pins[$];
  int          fail_total;
  int          read_total;
  int          result_index;

  // Start clocking in the data byte
  function void start_receive();
    wave_phase = WAVE_RECEIVE;
    bits_left  = 5'(BYTE_LAST_BIT);
    sck_high   = 1'b0;
  endfunction

  // Let go of the data line, then wait the sample delay if there is one
  function void begin_sample();
    line_driven = 1'b0;
    if (sample_ticks == 8'd0) begin
      start_receive();
    end else begin
      wave_phase = WAVE_SAMPLE;
      wait_left  = sample_ticks - 8'd1;
    end
  endfunction

  // Advance the waveform by one tick and return the pin levels after it
  function pin_levels_t next_pins(logic start, logic wr, logic [6:0] addr,
                                  logic [7:0] data, logic line);
    pin_levels_t p;
    p = '0;
    case (wave_phase)
      WAVE_IDLE: begin
        if (start) begin
          line_driven = 1'b1;
          sck_high    = 1'b0;
          if (wr) begin
            tx_shift   = {1'b1, addr, data};
            bits_left  = 5'(WRITE_LAST_BIT);
            wave_phase = WAVE_SEND_WRITE;
          end else begin
            tx_shift   = {1'b0, addr, 8'h00};
            bits_left  = 5'(BYTE_LAST_BIT);
            wave_phase = WAVE_SEND_READ;
          end
        end
      end
      WAVE_SEND_WRITE, WAVE_SEND_READ: begin
        if (!sck_high) begin
          sck_high = 1'b1;
        end else if (bits_left == 5'd0) begin
          if (wave_phase == WAVE_SEND_WRITE) begin
            wave_phase = WAVE_IDLE;
          end else if (release_ticks == 8'd0) begin
            begin_sample();
          end else begin
            wave_phase = WAVE_RELEASE;
            wait_left  = release_ticks - 8'd1;
          end
        end else begin
          bits_left = bits_left - 5'd1;
          tx_shift  = tx_shift << 1;
          sck_high  = 1'b0;
        end
      end
      WAVE_RELEASE: begin
        if (wait_left == 8'd0) begin
          begin_sample();
        end else begin
          wait_left = wait_left - 8'd1;
        end
      end
      WAVE_SAMPLE: begin
        if (wait_left == 8'd0) begin
          start_receive();
        end else begin
          wait_left = wait_left - 8'd1;
        end
      end
      WAVE_RECEIVE: begin
        if (!sck_high) begin
          sck_high = 1'b1;
          rx_shift = {rx_shift[6:0], line};
        end else if (bits_left == 5'd0) begin
          wave_phase  = WAVE_IDLE;
          line_driven = 1'b1;
          p.rvalid    = 1'b1;
          p.rdata     = rx_shift;
        end else begin
          bits_left = bits_left - 5'd1;
          sck_high  = 1'b0;
        end
      end
      default: begin
        wave_phase = WAVE_IDLE;
        sck_high   = 1'b1;
      end
    endcase
    p.sck   = sck_high;
    p.sdo   = line_driven & tx_shift[15];
    p.drive = line_driven;
    p.busy  = (wave_phase != WAVE_IDLE);
    return p;
  endfunction

  always @(posedge clk) begin
    pin_levels_t got;
    pin_levels_t want;
    if (rst) begin
      // Drop back to the idle waveform and the reset delays
      wave_phase    = WAVE_IDLE;
      bits_left     = 5'd0;
      sck_high      = 1'b1;
      wait_left     = 8'd0;
      tx_shift      = 16'd0;
      rx_shift      = 8'd0;
      line_driven   = 1'b0;
      release_ticks = RELEASE_DELAY_RESET;
      sample_ticks  = SAMPLE_DELAY_RESET;
      expected_pins.delete();
    end else begin
      // Track delay register writes
      if (cfg_write) begin
        case (cfg_index_t'(cfg_index))
          CFG_RELEASE_DELAY: release_ticks = cfg_data;
          CFG_SAMPLE_DELAY:  sample_ticks  = cfg_data;
          default: ;
        endcase
      end

      // Compare a result word against the oldest prediction
      if (out_valid && out_ready) begin
        got = '{sck_level, sdio_out, sdio_drive, busy_res, read_valid, read_data};
        if (expected_pins.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("result word %0d arrived with no prediction waiting: %h",
                     result_index, got);
        end else begin
          want = expected_pins.pop_front();
          if (want.rvalid) read_total++;
          if (got !== want) begin
            fail_total++;
            if (fail_total <= 10)
              $display({"result word %0d: expected sck %b sdo %b drive %b busy %b",
                        " rvalid %b rdata %h, got sck %b sdo %b drive %b busy %b",
                        " rvalid %b rdata %h"}, result_index,
                       want.sck, want.sdo, want.drive, want.busy, want.rvalid,
                       want.rdata, got.sck, got.sdo, got.drive, got.busy,
                       got.rvalid, got.rdata);
          end
        end
        result_index++;
      end

      // Predict the pins of each accepted tick word
      if (in_valid && in_ready)
        expected_pins.push_back(next_pins(start_req, is_write, reg_address,
                                          write_data, sdio_in));
    end
    mismatches <= fail_total;
    pending    <= expected_pins.size();
    bytes_read <= read_total;
  end

endmodule

/* tb/tb_sdio_serial_register_master.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sdio_serial_register_master
// Drives tick words into the serial register master with random gaps and
// result stalls, across several release and sample delay settings; a
// checker beside the block predicts and compares every pin-level word.
// ----------------------------------------------------------------------------

module tb_sdio_serial_register_master;
  import sdio_pkg::*;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [0:0] cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic       start_req;
  logic       is_write;
  logic [6:0] reg_address;
  logic [7:0] write_data;
  logic       sdio_in;
  logic       out_valid;
  logic       out_ready;
  logic       sck_level;
  logic       sdio_out;
  logic       sdio_drive;
  logic       busy_res;
  logic       read_valid;
  logic [7:0] read_data;

  int mismatches;
  int pending;
  int bytes_read;
  int words_sent;
  int settings_run;
  bit in_steady;
  bit out_steady;

  sdio_serial_register_master i_dut (
    .clk, .rst,
    .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .start_req, .is_write, .reg_address, .write_data,
    .sdio_in,
    .out_valid, .out_ready, .sck_level, .sdio_out, .sdio_drive, .busy_res,
    .read_valid, .read_data
  );

  sdio_pin_checker i_checker (
    .clk, .rst,
    .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .start_req, .is_write, .reg_address, .write_data,
    .sdio_in,
    .out_valid, .out_ready, .sck_level, .sdio_out, .sdio_drive, .busy_res,
    .read_valid, .read_data,
    .mismatches, .pending, .bytes_read
  );

  // Start low so the first rising edge comes after time zero
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Hand one tick word to the block after a random gap
  task automatic send_word(input logic start, input logic wr, input logic [6:0] addr,
                           input logic [7:0] data, input logic line);
    int gap;
    if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    start_req   <= start;
    is_write    <= wr;
    reg_address <= addr;
    write_data  <= data;
    sdio_in     <= line;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Send n words with fixed fields; line_mode 0 or 1 holds the data line, 2 randomizes it
  task automatic send_words(input int n, input logic start, input logic wr,
                            input logic [6:0] addr, input logic [7:0] data,
                            input int line_mode);
    for (int i = 0; i < n; i++)
      send_word(start, wr, addr, data,
                line_mode == 2 ? 1'($urandom_range(0, 1)) : line_mode[0]);
  endtask

  // Stop sending and wait until every predicted word has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write both delay registers on back-to-back cycles
  task automatic set_delays(input logic [7:0] rel, input logic [7:0] samp);
    cfg_write <= 1'b1;
    cfg_index <= CFG_RELEASE_DELAY;
    cfg_data  <= rel;
    @(posedge clk);
    cfg_index <= CFG_SAMPLE_DELAY;
    cfg_data  <= samp;
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_run++;
  endtask

  // Result side: stall for a random number of cycles before each word
  initial begin
    int stall;
    out_ready <= 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
      stall = out_steady ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Hard stop if the run hangs
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [7:0] rel_set[7];
    logic [7:0] samp_set[7];
    int tail;
    rel_set  = '{8'd0, 8'd1, 8'd2, 8'd0, 8'd3, 8'd0, 8'd0};
    samp_set = '{8'd0, 8'd1, 8'd0, 8'd5, 8'd0, 8'd3, 8'd0};
    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_index   <= CFG_RELEASE_DELAY;
    cfg_data    <= 8'd0;
    in_valid    <= 1'b0;
    start_req   <= 1'b0;
    is_write    <= 1'b0;
    reg_address <= 7'd0;
    write_data  <= 8'd0;
    sdio_in     <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // One read with the delays left at their reset values
    send_words(1, 1'b1, 1'b0, 7'h2A, 8'h00, 2);
    send_words(140, 1'b0, 1'b0, 7'h2A, 8'h00, 2);
    drain();

    // Zero delays: writes and reads at the field extremes
    set_delays(8'd0, 8'd0);
    send_words(1, 1'b1, 1'b1, 7'h7F, 8'hFF, 1);
    send_words(36, 1'b0, 1'b1, 7'h7F, 8'hFF, 1);
    send_words(1, 1'b1, 1'b1, 7'h00, 8'h00, 0);
    send_words(36, 1'b0, 1'b1, 7'h00, 8'h00, 0);
    send_words(1, 1'b1, 1'b0, 7'h7F, 8'h00, 1);
    send_words(36, 1'b0, 1'b0, 7'h7F, 8'h00, 1);
    send_words(1, 1'b1, 1'b0, 7'h00, 8'hFF, 0);
    send_words(36, 1'b0, 1'b0, 7'h00, 8'hFF, 0);
    // Hold start high: requests while busy and on the completion tick are ignored
    send_words(40, 1'b1, 1'b1, 7'h55, 8'hAA, 2);
    send_words(40, 1'b1, 1'b0, 7'h2A, 8'h55, 2);
    send_words(30, 1'b0, 1'b0, 7'h2A, 8'h55, 2);
    drain();

    // Random ticks under each delay setting; end each with a quiet tail
    rel_set[6]  = 8'($urandom_range(0, 7));
    samp_set[6] = 8'($urandom_range(0, 7));
    for (int s = 0; s < 7; s++) begin
      set_delays(rel_set[s], samp_set[s]);
      for (int i = 0; i < 15; i++)
        send_word($urandom_range(0, 99) < 20, 1'($urandom_range(0, 1)),
                  7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      tail = int'(rel_set[s]) + int'(samp_set[s]) + 34;
      send_words(tail, 1'b0, 1'b0, 7'h00, 8'h00, 2);
      drain();
    end

    repeat (4) @(posedge clk);
    $display("Sent %0d tick words under %0d delay settings plus the reset values;",
             words_sent, settings_run);
    $display("%0d read bytes came back among the checked pin words.", bytes_read);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sdio_pkg.sv
rtl/sdio_serial_register_master.sv
tb/sdio_pin_checker.sv
tb/tb_sdio_serial_register_master.sv
